// File: hw/rtl/itoa_fmt_pkg.sv
// Shared constants, command/status types and the digit-to-ASCII function.
package itoa_fmt_pkg;

  // Formatter sizing
  localparam int MAX_WIDTH   = 63;
  localparam int INT_BITS    = 16;
  localparam int DIGIT_SLOTS = 11;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int CONV_W  = 2;
  localparam int FW_W    = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int CNT_W   = $clog2(DIGIT_SLOTS + 1);
  localparam int IDX_W   = $clog2(DIGIT_SLOTS);

  // Mask of the short integer bits
  localparam logic [VALUE_W-1:0] LOW_MASK = VALUE_W'((64'd1 << INT_BITS) - 64'd1);

  // ceil(2^35 / 10): floor(v * RECIP10 / 2^35) == v / 10 for every 32-bit v
  localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  // Conversion codes
  typedef enum logic [CONV_W-1:0] {
    CONV_SDEC = 2'd0,
    CONV_UDEC = 2'd1,
    CONV_HEXL = 2'd2,
    CONV_HEXU = 2'd3
  } conv_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic emit_last;
  } dp_status_t;

  // One digit (0..15) to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dz;
    dz = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DIGIT_W'(10)) begin
      digit_char = CHAR_ZERO + dz;
    end else if (upper) begin
      digit_char = CHAR_UPPER_A + dz - 8'd10;
    end else begin
      digit_char = CHAR_LOWER_A + dz - 8'd10;
    end
  endfunction

endpackage

// File: hw/rtl/itoa_fmt_ctrl.sv
// Sequencing state machine: load, division steps, character emission.
module itoa_fmt_ctrl
  import itoa_fmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: hw/rtl/itoa_fmt_dp.sv
// Datapath: operand prep, one-digit-per-cycle division, digit store, output register.
module itoa_fmt_dp
  import itoa_fmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [CONV_W-1:0]   in_conversion,
  input  logic                in_long_flag,
  input  logic                in_zero_fill,
  input  logic [FW_W-1:0]     in_field_width,
  output logic                out_valid,
  output logic [CHAR_W-1:0]   out_character,
  output logic                out_last
);

  // Request state
  logic [VALUE_W-1:0] quot_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [FW_W-1:0]    pad_r;
  logic               sign_r;
  logic               hex_r;
  logic               upper_r;
  logic               zpad_r;
  logic [FW_W-1:0]    width_r;
  logic [DIGIT_W-1:0] digits_r [DIGIT_SLOTS];

  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  // Operand prep for a new request
  conv_t              conv;
  logic               is_sdec;
  logic [VALUE_W-1:0] v_ext;
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [FW_W-1:0]    width_clamped;

  assign conv    = conv_t'(in_conversion);
  assign is_sdec = (conv == CONV_SDEC);

  always_comb begin
    if (in_long_flag) begin
      v_ext = in_value;
    end else if (is_sdec && in_value[INT_BITS-1]) begin
      v_ext = in_value | ~LOW_MASK;
    end else begin
      v_ext = in_value & LOW_MASK;
    end
    neg = is_sdec && v_ext[VALUE_W-1];
    mag = neg ? (VALUE_W'(0) - v_ext) : v_ext;
    width_clamped = (in_field_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : in_field_width;
  end

  // Division step: base 10 by reciprocal multiply, base 16 by shift
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   q10;
  logic [VALUE_W-1:0]   r10;
  logic [VALUE_W-1:0]   q_nxt;
  logic [DIGIT_W-1:0]   digit;
  logic [CNT_W-1:0]     cnt_inc;
  logic [FW_W:0]        total;
  logic [FW_W-1:0]      pad_calc;

  always_comb begin
    prod    = {{VALUE_W{1'b0}}, quot_r} * {{VALUE_W{1'b0}}, RECIP10};
    q10     = VALUE_W'(prod >> RECIP_SHIFT);
    r10     = quot_r - (q10 << 3) - (q10 << 1);
    q_nxt   = hex_r ? (quot_r >> DIGIT_W) : q10;
    digit   = hex_r ? quot_r[DIGIT_W-1:0] : r10[DIGIT_W-1:0];
    cnt_inc = cnt_r + CNT_W'(1);
    total   = (FW_W+1)'(cnt_inc) + (FW_W+1)'(sign_r);
    pad_calc = ({1'b0, width_r} > total) ? FW_W'({1'b0, width_r} - total) : FW_W'(0);
  end

  assign status.div_done = (q_nxt == VALUE_W'(0)) || (cnt_inc == CNT_W'(DIGIT_SLOTS));

  // Emission: padding, then sign, then digits most significant first
  logic [CNT_W-1:0]  rd_cnt;
  logic [CHAR_W-1:0] emit_char;

  assign rd_cnt = cnt_r - CNT_W'(1);
  assign status.emit_last = (pad_r == FW_W'(0)) && !sign_r && (cnt_r == CNT_W'(1));

  always_comb begin
    if (pad_r != FW_W'(0)) begin
      emit_char = zpad_r ? CHAR_ZERO : CHAR_SPACE;
    end else if (sign_r) begin
      emit_char = CHAR_MINUS;
    end else begin
      emit_char = digit_char(digits_r[rd_cnt[IDX_W-1:0]], upper_r);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_r      <= '0;
      cnt_r       <= '0;
      pad_r       <= '0;
      sign_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        quot_r <= mag;
        cnt_r  <= '0;
        pad_r  <= '0;
        sign_r <= neg;
      end else if (cmd.div_step) begin
        quot_r <= q_nxt;
        cnt_r  <= cnt_inc;
        pad_r  <= pad_calc;
      end else if (cmd.emit) begin
        if (pad_r != FW_W'(0)) begin
          pad_r <= pad_r - FW_W'(1);
        end else if (sign_r) begin
          sign_r <= 1'b0;
        end else begin
          cnt_r <= rd_cnt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex_r   <= in_conversion[CONV_W-1];
      upper_r <= (conv == CONV_HEXU);
      zpad_r  <= in_zero_fill;
      width_r <= width_clamped;
    end
    if (cmd.div_step) begin
      digits_r[cnt_r[IDX_W-1:0]] <= digit;
    end
    out_char_r <= emit_char;
    out_last_r <= cmd.emit && status.emit_last;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

// File: hw/rtl/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter: %d %u %x %X with long flag and padded field width.
// A request with D digits (1..10 decimal, 1..8 hex) goes through the divider one digit per
// cycle, decimal by reciprocal multiply and hex by shift, then emits one character per cycle.
// The output is N = max(width, D+sign) characters; busy stays high through the division and
// emission states, and a new request is taken only once the controller is back in idle.
// Output is registered; the receiver cannot stall and takes each character on out_valid.
// Synchronous active-low reset returns the controller to idle; no clearing pass is needed.
module integer_to_ascii_formatter_top
  import itoa_fmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [CONV_W-1:0]  in_conversion,
  input  logic               in_long_flag,
  input  logic               in_zero_fill,
  input  logic [FW_W-1:0]    in_field_width,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  itoa_fmt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath
  itoa_fmt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_value),
    .in_conversion  (in_conversion),
    .in_long_flag   (in_long_flag),
    .in_zero_fill   (in_zero_fill),
    .in_field_width (in_field_width),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_last       (out_last)
  );

endmodule
